### rtl/ipdr_pkg.sv
package ipdr_pkg;

    localparam int MSG_DEPTH   = 1024;
    localparam int COUNT_WIDTH = 16;
    localparam int ADDR_W      = $clog2(MSG_DEPTH);
    localparam int CNT_W       = $clog2(MSG_DEPTH + 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 64;

    localparam logic [2:0] REQ_SERIAL  = 3'd0;
    localparam logic [2:0] REQ_READ    = 3'd1;
    localparam logic [2:0] REQ_RELEASE = 3'd2;
    localparam logic [2:0] REQ_FLAGS   = 3'd3;
    localparam logic [2:0] REQ_TAKE    = 3'd4;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_A    = 2'd1;
    localparam logic [1:0] CMD_B    = 2'd2;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_I  = 8'h49;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_UP_D  = 8'h44;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;

    localparam logic [4:0] GOTIP_LEN  = 5'd11;
    localparam logic [4:0] CLOSED_LEN = 5'd6;
    localparam logic [4:0] DISC_LEN   = 5'd15;

    localparam logic [3:0] TEN = 4'd10;

    typedef enum logic [2:0] {
        OP_SERIAL,
        OP_READ,
        OP_RELEASE,
        OP_FLAGS,
        OP_TAKE,
        OP_NONE
    } op_t;

    typedef struct packed {
        logic       is_plus;
        logic       is_i;
        logic       is_p;
        logic       is_d;
        logic       is_comma;
        logic       is_colon;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_a;
        logic       is_b;
    } byte_class_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  rx_byte;
        byte_class_t cls;
        logic [9:0]  read_index;
        logic [2:0]  link_flags_in;
    } item_t;

    typedef struct packed {
        logic        wifi_up;
        logic        tcp_up;
        logic        is_registered;
        logic        frame_ready;
        logic [10:0] frame_length;
        logic [7:0]  read_data;
        logic [1:0]  command_code;
        logic [15:0] dropped_frames;
        logic [15:0] cut_frames;
    } result_t;

    function automatic logic [7:0] gotip_char(input logic [4:0] pos);
        unique case (pos)
            5'd0:    return 8'h57;
            5'd1:    return 8'h49;
            5'd2:    return 8'h46;
            5'd3:    return 8'h49;
            5'd4:    return 8'h20;
            5'd5:    return 8'h47;
            5'd6:    return 8'h4F;
            5'd7:    return 8'h54;
            5'd8:    return 8'h20;
            5'd9:    return 8'h49;
            5'd10:   return 8'h50;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] closed_char(input logic [4:0] pos);
        unique case (pos)
            5'd0:    return 8'h43;
            5'd1:    return 8'h4C;
            5'd2:    return 8'h4F;
            5'd3:    return 8'h53;
            5'd4:    return 8'h45;
            5'd5:    return 8'h44;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] disc_char(input logic [4:0] pos);
        unique case (pos)
            5'd0:    return 8'h57;
            5'd1:    return 8'h49;
            5'd2:    return 8'h46;
            5'd3:    return 8'h49;
            5'd4:    return 8'h20;
            5'd5:    return 8'h44;
            5'd6:    return 8'h49;
            5'd7:    return 8'h53;
            5'd8:    return 8'h43;
            5'd9:    return 8'h4F;
            5'd10:   return 8'h4E;
            5'd11:   return 8'h4E;
            5'd12:   return 8'h45;
            5'd13:   return 8'h43;
            5'd14:   return 8'h54;
            default: return 8'h00;
        endcase
    endfunction

endpackage

### rtl/ipdr_front.sv
module ipdr_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ipdr_pkg::IN_TUSER_W-1:0] s_tuser,
    input  logic [ipdr_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                            q_full,
    output logic                            q_push,
    output ipdr_pkg::item_t                 q_item
);
    import ipdr_pkg::*;

    logic [7:0] b;

    assign b        = s_tdata[7:0];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        unique case (s_tuser)
            REQ_SERIAL:  q_item.op = OP_SERIAL;
            REQ_READ:    q_item.op = OP_READ;
            REQ_RELEASE: q_item.op = OP_RELEASE;
            REQ_FLAGS:   q_item.op = OP_FLAGS;
            REQ_TAKE:    q_item.op = OP_TAKE;
            default:     q_item.op = OP_NONE;
        endcase
        q_item.rx_byte          = b;
        q_item.read_index       = s_tdata[17:8];
        q_item.link_flags_in    = s_tdata[20:18];
        q_item.cls.is_plus      = (b == CH_PLUS);
        q_item.cls.is_i         = (b == CH_UP_I);
        q_item.cls.is_p         = (b == CH_UP_P);
        q_item.cls.is_d         = (b == CH_UP_D);
        q_item.cls.is_comma     = (b == CH_COMMA);
        q_item.cls.is_colon     = (b == CH_COLON);
        q_item.cls.is_digit     = (b >= CH_ZERO) && (b <= CH_NINE);
        q_item.cls.digit        = 4'(b - CH_ZERO);
        q_item.cls.is_a         = (b == CH_LO_A);
        q_item.cls.is_b         = (b == CH_LO_B);
    end

endmodule

### rtl/ipdr_queue.sv
module ipdr_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ipdr_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output ipdr_pkg::item_t head_item
);
    import ipdr_pkg::*;

    item_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign valid     = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= QPTR_W'((32'(wr_ptr_reg) + 1) % QDEPTH);
            end
            if (pop) begin
                rd_ptr_reg <= QPTR_W'((32'(rd_ptr_reg) + 1) % QDEPTH);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/ipdr_back.sv
module ipdr_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  ipdr_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output ipdr_pkg::result_t out_result
);
    import ipdr_pkg::*;

    typedef enum logic [2:0] {
        HDR_IDLE,
        HDR_PLUS,
        HDR_I,
        HDR_P,
        HDR_D,
        HDR_LEN,
        HDR_PAYLOAD
    } hdr_t;

    hdr_t                   hdr_reg, hdr_next;
    logic [15:0]            bytes_left_reg, bytes_left_next;
    logic [CNT_W-1:0]       stored_reg, stored_next;
    logic                   ready_reg, ready_next;
    logic                   dropping_reg, dropping_next;
    logic                   cut_reg, cut_next;
    logic [COUNT_WIDTH-1:0] drop_cnt_reg, drop_cnt_next;
    logic [COUNT_WIDTH-1:0] cut_cnt_reg, cut_cnt_next;
    logic [2:0]             flags_reg, flags_next;
    logic [3:0]             gotip_reg, gotip_next;
    logic [2:0]             closed_reg, closed_next;
    logic [3:0]             disc_reg, disc_next;
    logic [1:0]             latch_reg, latch_next;

    logic                   out_valid_reg;
    logic [2:0]             out_flags_reg;
    logic                   out_ready_flag_reg;
    logic [CNT_W-1:0]       out_stored_reg;
    logic                   out_rd_sel_reg;
    logic [1:0]             out_cmd_reg;
    logic [COUNT_WIDTH-1:0] out_drop_reg;
    logic [COUNT_WIDTH-1:0] out_cut_reg;

    logic [7:0]             mem [MSG_DEPTH];
    logic [7:0]             mem_q_reg;

    logic                   fire;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_W-1:0]      raddr;
    logic                   rd_in_range;
    logic [1:0]             cmd_out;
    logic [4:0]             gp, cp, dp;
    logic [15:0]            bl_dec;
    logic [31:0]            stored_wide;

    function automatic logic [4:0] match_adv(input logic [4:0] pos, input logic [4:0] len,
                                             input logic [7:0] b, input logic [7:0] exp_c,
                                             input logic [7:0] first_c);
        if ((pos < len) && (b == exp_c)) begin
            return pos + 5'd1;
        end else if (b == first_c) begin
            return 5'd1;
        end else begin
            return 5'd0;
        end
    endfunction

    assign fire        = q_valid && (!out_valid_reg || out_ready);
    assign q_pop       = fire;
    assign rd_in_range = (32'(q_item.read_index) < MSG_DEPTH);
    assign raddr       = ADDR_W'(32'(q_item.read_index));
    assign bl_dec      = bytes_left_reg - 16'd1;

    always_comb begin
        hdr_next        = hdr_reg;
        bytes_left_next = bytes_left_reg;
        stored_next     = stored_reg;
        ready_next      = ready_reg;
        dropping_next   = dropping_reg;
        cut_next        = cut_reg;
        drop_cnt_next   = drop_cnt_reg;
        cut_cnt_next    = cut_cnt_reg;
        flags_next      = flags_reg;
        gotip_next      = gotip_reg;
        closed_next     = closed_reg;
        disc_next       = disc_reg;
        latch_next      = latch_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        cmd_out         = CMD_NONE;
        gp              = '0;
        cp              = '0;
        dp              = '0;

        if (fire) begin
            unique case (q_item.op)
                OP_SERIAL: begin
                    if (hdr_reg != HDR_PAYLOAD) begin
                        gp = match_adv({1'b0, gotip_reg}, GOTIP_LEN, q_item.rx_byte,
                                       gotip_char({1'b0, gotip_reg}), gotip_char(5'd0));
                        cp = match_adv({2'b00, closed_reg}, CLOSED_LEN, q_item.rx_byte,
                                       closed_char({2'b00, closed_reg}), closed_char(5'd0));
                        dp = match_adv({1'b0, disc_reg}, DISC_LEN, q_item.rx_byte,
                                       disc_char({1'b0, disc_reg}), disc_char(5'd0));
                        if (gp >= GOTIP_LEN) begin
                            gotip_next    = '0;
                            flags_next[0] = 1'b1;
                        end else begin
                            gotip_next = 4'(gp);
                        end
                        if (cp >= CLOSED_LEN) begin
                            closed_next = '0;
                            flags_next  = flags_next & 3'b001;
                        end else begin
                            closed_next = 3'(cp);
                        end
                        if (dp >= DISC_LEN) begin
                            disc_next  = '0;
                            flags_next = 3'b000;
                        end else begin
                            disc_next = 4'(dp);
                        end
                    end

                    unique case (hdr_reg)
                        HDR_IDLE: begin
                            if (q_item.cls.is_plus) begin
                                hdr_next = HDR_PLUS;
                            end
                        end
                        HDR_PLUS: hdr_next = q_item.cls.is_i ? HDR_I : HDR_IDLE;
                        HDR_I:    hdr_next = q_item.cls.is_p ? HDR_P : HDR_IDLE;
                        HDR_P:    hdr_next = q_item.cls.is_d ? HDR_D : HDR_IDLE;
                        HDR_D: begin
                            if (q_item.cls.is_comma) begin
                                bytes_left_next = '0;
                                hdr_next        = HDR_LEN;
                            end else begin
                                hdr_next = HDR_IDLE;
                            end
                        end
                        HDR_LEN: begin
                            if (q_item.cls.is_digit) begin
                                bytes_left_next = {bytes_left_reg[12:0], 3'b000}
                                                + {bytes_left_reg[14:0], 1'b0}
                                                + 16'(q_item.cls.digit);
                            end else if (q_item.cls.is_colon && (bytes_left_reg != '0)) begin
                                if (ready_reg) begin
                                    dropping_next = 1'b1;
                                    if (drop_cnt_reg != '1) begin
                                        drop_cnt_next = drop_cnt_reg + 1'b1;
                                    end
                                end else begin
                                    dropping_next = 1'b0;
                                    stored_next   = '0;
                                    gotip_next    = '0;
                                    disc_next     = '0;
                                end
                                cut_next = 1'b0;
                                hdr_next = HDR_PAYLOAD;
                            end else begin
                                hdr_next = HDR_IDLE;
                            end
                        end
                        HDR_PAYLOAD: begin
                            if (!dropping_reg) begin
                                if (32'(stored_reg) < MSG_DEPTH) begin
                                    mem_we      = 1'b1;
                                    stored_next = stored_reg + 1'b1;
                                end else if (!cut_reg) begin
                                    cut_next = 1'b1;
                                    if (cut_cnt_reg != '1) begin
                                        cut_cnt_next = cut_cnt_reg + 1'b1;
                                    end
                                end
                            end
                            bytes_left_next = bl_dec;
                            if (bl_dec == '0) begin
                                if (!dropping_reg) begin
                                    ready_next = 1'b1;
                                end
                                dropping_next = 1'b0;
                                cut_next      = 1'b0;
                                hdr_next      = HDR_IDLE;
                            end
                        end
                        default: hdr_next = HDR_IDLE;
                    endcase

                    if (q_item.cls.is_a) begin
                        latch_next = CMD_A;
                    end else if (q_item.cls.is_b) begin
                        latch_next = CMD_B;
                    end
                end
                OP_READ:    mem_re = rd_in_range;
                OP_RELEASE: ready_next = 1'b0;
                OP_FLAGS:   flags_next = q_item.link_flags_in;
                OP_TAKE: begin
                    cmd_out    = latch_reg;
                    latch_next = CMD_NONE;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg        <= HDR_IDLE;
            bytes_left_reg <= '0;
            stored_reg     <= '0;
            ready_reg      <= 1'b0;
            dropping_reg   <= 1'b0;
            cut_reg        <= 1'b0;
            drop_cnt_reg   <= '0;
            cut_cnt_reg    <= '0;
            flags_reg      <= '0;
            gotip_reg      <= '0;
            closed_reg     <= '0;
            disc_reg       <= '0;
            latch_reg      <= CMD_NONE;
            out_valid_reg  <= 1'b0;
        end else begin
            hdr_reg        <= hdr_next;
            bytes_left_reg <= bytes_left_next;
            stored_reg     <= stored_next;
            ready_reg      <= ready_next;
            dropping_reg   <= dropping_next;
            cut_reg        <= cut_next;
            drop_cnt_reg   <= drop_cnt_next;
            cut_cnt_reg    <= cut_cnt_next;
            flags_reg      <= flags_next;
            gotip_reg      <= gotip_next;
            closed_reg     <= closed_next;
            disc_reg       <= disc_next;
            latch_reg      <= latch_next;
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_flags_reg      <= flags_next;
            out_ready_flag_reg <= ready_next;
            out_stored_reg     <= stored_next;
            out_rd_sel_reg     <= mem_re;
            out_cmd_reg        <= cmd_out;
            out_drop_reg       <= drop_cnt_next;
            out_cut_reg        <= cut_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[stored_reg[ADDR_W-1:0]] <= q_item.rx_byte;
        end
        if (mem_re) begin
            mem_q_reg <= mem[raddr];
        end
    end

    assign stored_wide = 32'(out_stored_reg);
    assign out_valid   = out_valid_reg;

    always_comb begin
        out_result.wifi_up        = out_flags_reg[0];
        out_result.tcp_up         = out_flags_reg[1];
        out_result.is_registered  = out_flags_reg[2];
        out_result.frame_ready    = out_ready_flag_reg;
        out_result.frame_length   = out_ready_flag_reg ? stored_wide[10:0] : 11'd0;
        out_result.read_data      = out_rd_sel_reg ? mem_q_reg : 8'd0;
        out_result.command_code   = out_cmd_reg;
        out_result.dropped_frames = 16'(32'(out_drop_reg));
        out_result.cut_frames     = 16'(32'(out_cut_reg));
    end

endmodule

### rtl/at_stream_ipd_receive_parser_core.sv
// Receive parser for the AT serial stream of a Wi-Fi modem, with host requests.
// The slave channel carries one item per transfer: s_tuser holds the request
// kind (serial byte, read message byte, release frame, write link flags, take
// command) and s_tdata holds the operands. The master channel returns exactly
// one status item per accepted item, in order, on m_tdata.
// The front end decodes and classifies each item and pushes it into a
// four-entry queue. The back end executes one item per cycle, while its result
// register is free or being taken, against the header state machine, the three
// text matchers and the message memory, and registers the result together with
// the memory read data. Throughput is one item per cycle while results are taken,
// set by the execute stage. An accepted item is written into the queue, and its
// result is registered by the execute stage when the item leaves the queue.
// When the receiver stalls, the held result stays stable, the back end stops,
// and the queue keeps accepting until it holds four items.
// Reset clears all control state, the link flags, the counters and the queue.
// The message memory is not cleared; the host must read only written bytes, unchecked.
module at_stream_ipd_receive_parser_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // req_type[2:0]
    input  logic [ipdr_pkg::IN_TUSER_W-1:0]  s_tuser,
    // rx_byte[7:0], read_index[17:8], link_flags_in[20:18], zero [23:21]
    input  logic [ipdr_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // wifi_up[0], tcp_up[1], is_registered[2], frame_ready[3], frame_length[14:4],
    // read_data[22:15], command_code[24:23], dropped_frames[40:25],
    // cut_frames[56:41], zero [63:57]
    output logic [ipdr_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ipdr_pkg::*;

    logic    q_full;
    logic    q_push;
    item_t   push_item;
    logic    q_pop;
    logic    q_valid;
    item_t   head_item;
    result_t result;

    ipdr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    ipdr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_item (head_item)
    );

    ipdr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {7'd0,
                      result.cut_frames,
                      result.dropped_frames,
                      result.command_code,
                      result.read_data,
                      result.frame_length,
                      result.frame_ready,
                      result.is_registered,
                      result.tcp_up,
                      result.wifi_up};

endmodule

### rtl/ipdr_checker.sv
module ipdr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [ipdr_pkg::IN_TUSER_W-1:0]  s_tuser,
    input logic [ipdr_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ipdr_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ipdr_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or vanished");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_length_needs_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[3]) |-> (m_tdata[14:4] == 11'd0))
        else $error("frame length reported with no frame waiting");

    a_cmd_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[24:23] != 2'd3) && (m_tdata[63:57] == 7'd0)))
        else $error("bad command code or padding");

    a_length_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:4] <= 11'(MSG_DEPTH)))
        else $error("frame length beyond the message memory");

endmodule

bind at_stream_ipd_receive_parser_core ipdr_checker u_ipdr_checker (.*);

### bench/tb_at_stream_ipd_receive_parser_core.sv
`timescale 1ns / 1ps

module tb_at_stream_ipd_receive_parser_core;

    import ipdr_pkg::*;

    localparam logic [2:0] REQ_RSVD_LO  = 3'd5;
    localparam logic [2:0] REQ_RSVD_MID = 3'd6;
    localparam logic [2:0] REQ_RSVD_HI  = 3'd7;

    localparam longint CNT_MAX      = (longint'(1) << COUNT_WIDTH) - 1;
    localparam int     STALL_CYCLES = 80;
    localparam int     N_DIRECTED   = 28;

    typedef enum logic [2:0] {
        H_IDLE,
        H_PLUS,
        H_I,
        H_P,
        H_D,
        H_LEN,
        H_BODY
    } hdr_t;

    typedef struct {
        logic [2:0] req;
        logic [7:0] rx;
        logic [9:0] idx;
        logic [2:0] fl;
        bit         typed;
        logic [2:0] flags_exp;
        logic [1:0] cmd_exp;
    } dir_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int  src_idle_pct  = 33;
    int  sink_idle_pct = 79;
    bit  hold_go       = 1'b0;
    bit  sink_hold     = 1'b0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  err_count     = 0;

    result_t status_q [$];

    string match_txt [3] = '{"WIFI GOT IP", "CLOSED", "WIFI DISCONNECT"};

    // Parser state as the host would see it after each item.
    hdr_t        hdr           = H_IDLE;
    logic [15:0] len_left      = '0;
    logic [7:0]  msg_mem [MSG_DEPTH];
    int          fill_cnt      = 0;
    int          written_top   = 0;
    bit          frame_waiting = 1'b0;
    bit          discarding    = 1'b0;
    bit          cut_flag      = 1'b0;
    longint      drop_cnt      = 0;
    longint      cut_cnt       = 0;
    logic [2:0]  link          = '0;
    int          gotip_pos     = 0;
    int          closed_pos    = 0;
    int          disc_pos      = 0;
    logic [1:0]  pend_cmd      = CMD_NONE;
    int          frames_stored = 0;

    dir_row_t directed [N_DIRECTED] = '{
        '{REQ_TAKE,     8'h00,            10'h000, 3'd0, 1'b1, 3'd0, CMD_NONE},
        '{REQ_RELEASE,  8'hFF,            10'h3FF, 3'd7, 1'b1, 3'd0, CMD_NONE},
        '{REQ_FLAGS,    8'h00,            10'h000, 3'd7, 1'b1, 3'd7, CMD_NONE},
        '{REQ_RSVD_LO,  CH_LO_A,          10'h3FF, 3'd0, 1'b1, 3'd7, CMD_NONE},
        '{REQ_RSVD_MID, 8'hFF,            10'h000, 3'd0, 1'b1, 3'd7, CMD_NONE},
        '{REQ_RSVD_HI,  CH_LO_B,          10'h3FF, 3'd0, 1'b1, 3'd7, CMD_NONE},
        '{REQ_FLAGS,    8'hFF,            10'h3FF, 3'd0, 1'b1, 3'd0, CMD_NONE},
        '{REQ_SERIAL,   8'h00,            10'h3FF, 3'd7, 1'b1, 3'd0, CMD_NONE},
        '{REQ_SERIAL,   8'hFF,            10'h000, 3'd0, 1'b1, 3'd0, CMD_NONE},
        '{REQ_SERIAL,   CH_LO_A,          10'h155, 3'd5, 1'b1, 3'd0, CMD_NONE},
        '{REQ_TAKE,     8'hFF,            10'h2AA, 3'd2, 1'b1, 3'd0, CMD_A},
        '{REQ_SERIAL,   CH_LO_B,          10'h2AA, 3'd2, 1'b1, 3'd0, CMD_NONE},
        '{REQ_TAKE,     8'h00,            10'h155, 3'd5, 1'b1, 3'd0, CMD_B},
        '{REQ_TAKE,     CH_LO_A,          10'h000, 3'd0, 1'b1, 3'd0, CMD_NONE},
        '{REQ_FLAGS,    8'h00,            10'h000, 3'd5, 1'b0, 3'd0, CMD_NONE},
        '{REQ_SERIAL,   CH_PLUS,          10'h000, 3'd0, 1'b0, 3'd0, CMD_NONE},
        '{REQ_SERIAL,   CH_UP_I,          10'h3FF, 3'd7, 1'b0, 3'd0, CMD_NONE},
        '{REQ_SERIAL,   CH_UP_P,          10'h000, 3'd0, 1'b0, 3'd0, CMD_NONE},
        '{REQ_SERIAL,   CH_UP_D,          10'h3FF, 3'd7, 1'b0, 3'd0, CMD_NONE},
        '{REQ_SERIAL,   CH_COMMA,         10'h000, 3'd0, 1'b0, 3'd0, CMD_NONE},
        '{REQ_SERIAL,   CH_ZERO + 8'd2,   10'h3FF, 3'd7, 1'b0, 3'd0, CMD_NONE},
        '{REQ_SERIAL,   CH_COLON,         10'h000, 3'd0, 1'b0, 3'd0, CMD_NONE},
        '{REQ_SERIAL,   CH_LO_A,          10'h3FF, 3'd7, 1'b0, 3'd0, CMD_NONE},
        '{REQ_SERIAL,   8'h5A,            10'h000, 3'd0, 1'b0, 3'd0, CMD_NONE},
        '{REQ_READ,     8'hFF,            10'd1,   3'd7, 1'b0, 3'd0, CMD_NONE},
        '{REQ_READ,     8'h00,            10'd0,   3'd0, 1'b0, 3'd0, CMD_NONE},
        '{REQ_TAKE,     8'h00,            10'h000, 3'd0, 1'b0, 3'd0, CMD_NONE},
        '{REQ_RELEASE,  8'h00,            10'h000, 3'd0, 1'b0, 3'd0, CMD_NONE}
    };

    at_stream_ipd_receive_parser_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),  // req_type
        .s_tdata  (s_tdata),  // rx_byte, read_index, link_flags_in, zero pad
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)   // wifi_up, tcp_up, is_registered, frame_ready,
                              // frame_length, read_data, command_code,
                              // dropped_frames, cut_frames, zero pad
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_error(input string msg);
        if (err_count < 40) begin
            $display("ERROR: %s", msg);
        end
        err_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want) begin
            report_error($sformatf("result %0d: %s is %0d, expected %0d",
                                   results_seen, name, got, want));
        end
    endtask

    function automatic bit match_advance(input logic [7:0] b, input string txt, inout int pos);
        if (pos < txt.len() && b == txt[pos]) begin
            pos++;
        end else begin
            pos = (b == txt[0]) ? 1 : 0;
        end
        if (pos >= txt.len()) begin
            pos = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t parse_step(input logic [2:0] req, input logic [7:0] b,
                                           input logic [9:0] idx, input logic [2:0] fl);
        result_t r;
        r = '0;
        case (req)
            REQ_SERIAL: begin
                if (hdr != H_BODY) begin
                    if (match_advance(b, match_txt[0], gotip_pos)) link[0] = 1'b1;
                    if (match_advance(b, match_txt[1], closed_pos)) link = link & 3'b001;
                    if (match_advance(b, match_txt[2], disc_pos)) link = 3'b000;
                end
                case (hdr)
                    H_IDLE: if (b == CH_PLUS) hdr = H_PLUS;
                    H_PLUS: hdr = (b == CH_UP_I) ? H_I : H_IDLE;
                    H_I:    hdr = (b == CH_UP_P) ? H_P : H_IDLE;
                    H_P:    hdr = (b == CH_UP_D) ? H_D : H_IDLE;
                    H_D: begin
                        if (b == CH_COMMA) begin
                            len_left = '0;
                            hdr = H_LEN;
                        end else begin
                            hdr = H_IDLE;
                        end
                    end
                    H_LEN: begin
                        if (b >= CH_ZERO && b <= CH_NINE) begin
                            len_left = len_left * 16'd10 + 16'(b - CH_ZERO);
                        end else if (b == CH_COLON && len_left != 0) begin
                            if (frame_waiting) begin
                                discarding = 1'b1;
                                if (drop_cnt < CNT_MAX) drop_cnt++;
                            end else begin
                                discarding = 1'b0;
                                fill_cnt = 0;
                                gotip_pos = 0;
                                disc_pos = 0;
                            end
                            cut_flag = 1'b0;
                            hdr = H_BODY;
                        end else begin
                            hdr = H_IDLE;
                        end
                    end
                    H_BODY: begin
                        if (!discarding) begin
                            if (fill_cnt < MSG_DEPTH) begin
                                msg_mem[fill_cnt] = b;
                                fill_cnt++;
                                if (fill_cnt > written_top) written_top = fill_cnt;
                            end else if (!cut_flag) begin
                                cut_flag = 1'b1;
                                if (cut_cnt < CNT_MAX) cut_cnt++;
                            end
                        end
                        len_left = len_left - 16'd1;
                        if (len_left == 0) begin
                            if (!discarding) begin
                                frame_waiting = 1'b1;
                                frames_stored++;
                            end
                            discarding = 1'b0;
                            cut_flag = 1'b0;
                            hdr = H_IDLE;
                        end
                    end
                    default: hdr = H_IDLE;
                endcase
                if (b == CH_LO_A) begin
                    pend_cmd = CMD_A;
                end else if (b == CH_LO_B) begin
                    pend_cmd = CMD_B;
                end
            end
            REQ_READ: begin
                if (int'(idx) < MSG_DEPTH) r.read_data = msg_mem[idx];
            end
            REQ_RELEASE: frame_waiting = 1'b0;
            REQ_FLAGS:   link = fl;
            REQ_TAKE: begin
                r.command_code = pend_cmd;
                pend_cmd = CMD_NONE;
            end
            default: ;
        endcase
        r.wifi_up        = link[0];
        r.tcp_up         = link[1];
        r.is_registered  = link[2];
        r.frame_ready    = frame_waiting;
        r.frame_length   = frame_waiting ? 11'(fill_cnt) : 11'd0;
        r.dropped_frames = 16'(drop_cnt);
        r.cut_frames     = 16'(cut_cnt);
        return r;
    endfunction

    task automatic send_item(input logic [2:0] req, input logic [7:0] rx,
                             input logic [9:0] idx, input logic [2:0] fl,
                             input bit typed = 1'b0, input logic [2:0] flags_exp = 3'd0,
                             input logic [1:0] cmd_exp = CMD_NONE);
        result_t want;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, fl, idx, rx};
        do @(posedge aclk); while (!s_tready);
        want = parse_step(req, rx, idx, fl);
        // Rows with typed set expect no frame, no read data and clear counters.
        if (typed) begin
            want = '0;
            {want.is_registered, want.tcp_up, want.wifi_up} = flags_exp;
            want.command_code = cmd_exp;
        end
        status_q.push_back(want);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(REQ_SERIAL, b, 10'($urandom_range(1023)), 3'($urandom_range(7)));
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_byte(txt[i]);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        string spice = "ab+IPD,:WC0";
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 8'($urandom_range(255));
            5, 6, 7:       return 8'($urandom_range(126, 32));
            default:       return spice[$urandom_range(spice.len() - 1)];
        endcase
    endfunction

    task automatic host_op();
        int         k;
        logic [9:0] idx;
        k = $urandom_range(99);
        if (k < 35 && written_top > 0) begin
            idx = ($urandom_range(4) == 0) ? 10'(written_top - 1)
                                           : 10'($urandom_range(written_top - 1));
            send_item(REQ_READ, 8'($urandom_range(255)), idx, 3'($urandom_range(7)));
        end else if (k < 60) begin
            send_item(REQ_RELEASE, 8'($urandom_range(255)), 10'($urandom_range(1023)),
                      3'($urandom_range(7)));
        end else if (k < 75) begin
            send_item(REQ_FLAGS, 8'($urandom_range(255)), 10'($urandom_range(1023)),
                      3'($urandom_range(7)));
        end else if (k < 90) begin
            send_item(REQ_TAKE, 8'($urandom_range(255)), 10'($urandom_range(1023)),
                      3'($urandom_range(7)));
        end else begin
            send_item(3'($urandom_range(REQ_RSVD_HI, REQ_RSVD_LO)), 8'($urandom_range(255)),
                      10'($urandom_range(1023)), 3'($urandom_range(7)));
        end
    endtask

    task automatic run_random(input int n_items);
        int         stop_at;
        int         pick;
        int         k;
        int         len_eff;
        int         len_txt;
        string      txt;
        string      emb;
        string      hdr_txt;
        logic [7:0] b;
        logic [7:0] body [$];
        hdr_txt = "+IPD,17:";
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 32) begin
                k = $urandom_range(99);
                if (k < 75) begin
                    len_eff = $urandom_range(24, 1);
                end else if (k < 87) begin
                    len_eff = $urandom_range(90, 25);
                end else if (k < 93) begin
                    len_eff = 0;
                end else begin
                    len_eff = $urandom_range(12, 1);
                end
                // Lengths past 16 bits wrap, so the length in the sent text may be much larger.
                len_txt = (k >= 93) ? len_eff + 65536 * $urandom_range(3, 1) : len_eff;
                txt = $sformatf("+IPD,%s%0d:", ($urandom_range(3) == 0) ? "0" : "", len_txt);
                send_text(txt);
                body.delete();
                repeat (len_eff) body.push_back(pick_byte());
                if (len_eff >= 15 && $urandom_range(2) == 0) begin
                    emb = ($urandom_range(3) == 0) ? "+IPD,9:" : match_txt[$urandom_range(2)];
                    for (int i = 0; i < emb.len() && i < body.size(); i++) begin
                        body[i] = emb[i];
                    end
                end
                foreach (body[i]) begin
                    if ($urandom_range(19) == 0) host_op();
                    send_byte(body[i]);
                end
            end else if (pick < 44) begin
                k = $urandom_range(7, 1);
                send_text(hdr_txt.substr(0, k - 1));
                b = pick_byte();
                if (b == hdr_txt[k] || (b >= CH_ZERO && b <= CH_COLON)) b = "#";
                send_byte(b);
            end else if (pick < 58) begin
                txt = match_txt[$urandom_range(2)];
                if ($urandom_range(4) == 0) txt = {"WIFI ", txt};
                if ($urandom_range(3) == 0) begin
                    txt.putc($urandom_range(txt.len() - 1), pick_byte());
                end
                send_text(txt);
            end else if (pick < 90) begin
                host_op();
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    b = pick_byte();
                    if (b == CH_PLUS) b = "*";
                    send_byte(b);
                end
            end
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (status_q.size() != 0);
    endtask

    initial begin
        wait (hold_go);
        sink_hold = 1'b1;
        repeat (STALL_CYCLES) @(posedge aclk);
        sink_hold = 1'b0;
    end

    initial begin
        result_t got;
        result_t want;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.wifi_up        = m_tdata[0];
                got.tcp_up         = m_tdata[1];
                got.is_registered  = m_tdata[2];
                got.frame_ready    = m_tdata[3];
                got.frame_length   = m_tdata[14:4];
                got.read_data      = m_tdata[22:15];
                got.command_code   = m_tdata[24:23];
                got.dropped_frames = m_tdata[40:25];
                got.cut_frames     = m_tdata[56:41];
                if (status_q.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing pending",
                                           results_seen));
                end else begin
                    want = status_q.pop_front();
                    check_field("wifi_up", got.wifi_up, want.wifi_up);
                    check_field("tcp_up", got.tcp_up, want.tcp_up);
                    check_field("is_registered", got.is_registered, want.is_registered);
                    check_field("frame_ready", got.frame_ready, want.frame_ready);
                    check_field("frame_length", got.frame_length, want.frame_length);
                    check_field("read_data", got.read_data, want.read_data);
                    check_field("command_code", got.command_code, want.command_code);
                    check_field("dropped_frames", got.dropped_frames, want.dropped_frames);
                    check_field("cut_frames", got.cut_frames, want.cut_frames);
                end
                results_seen++;
            end
            m_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= REQ_SERIAL;
        s_tdata  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            send_item(directed[i].req, directed[i].rx, directed[i].idx, directed[i].fl,
                      directed[i].typed, directed[i].flags_exp, directed[i].cmd_exp);
        end
        run_random(240);
        drain_results();

        src_idle_pct  = 79;
        sink_idle_pct = 33;
        run_random(240);
        drain_results();

        // Full rate while the result side stalls for a while.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_byte("*");
        send_item(REQ_RELEASE, 8'h00, 10'h000, 3'd0);
        hold_go = 1'b1;
        run_random(230);
        drain_results();
        repeat (20) @(posedge aclk);

        $display("Run covered %0d items and %0d results across three idle patterns.",
                 items_sent, results_seen);
        $display("Payloads: %0d stored, %0d dropped, %0d cut; %0d memory bytes written.",
                 frames_stored, drop_cnt, cut_cnt, written_top);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
